// File: hw/rtl/btd_pkg.sv
`default_nettype none

package btd_pkg;

    localparam int TAG_BITS    = 64;
    localparam int BOARD_TAG_W = 64;
    localparam int CMD_W       = 4;
    localparam int STATE_W     = 4;

    typedef enum logic [STATE_W-1:0] {
        ST_NOTCONN  = 4'd0,
        ST_SOCK     = 4'd1,
        ST_SVCDESC  = 4'd2,
        ST_IDLE     = 4'd3,
        ST_BOARD    = 4'd4,
        ST_READY    = 4'd5,
        ST_BOTH     = 4'd6,
        ST_TRANSP   = 4'd7,
        ST_STOPPED  = 4'd8,
        ST_FINISHED = 4'd9,
        ST_DISC     = 4'd10
    } t_state;

    typedef enum logic [CMD_W-1:0] {
        CMD_CL_SVCDESC    = 4'd0,
        CMD_CL_BOARDAVAIL = 4'd1,
        CMD_CL_REVOKE     = 4'd2,
        CMD_CL_FINISHED   = 4'd3,
        CMD_CL_NOTIF      = 4'd4,
        CMD_CL_ALIVE      = 4'd5,
        CMD_CL_DISCONNECT = 4'd6,
        CMD_PR_CONNECTED  = 4'd7,
        CMD_PR_SVCDESC    = 4'd8,
        CMD_PR_READY      = 4'd9,
        CMD_PR_REVOKERDY  = 4'd10,
        CMD_PR_START      = 4'd11,
        CMD_PR_STOP       = 4'd12,
        CMD_PR_NOTIF      = 4'd13,
        CMD_PR_ALIVE      = 4'd14,
        CMD_PR_CLOSED     = 4'd15
    } t_cmd;

    typedef enum logic [1:0] {
        FATAL_NONE  = 2'd0,
        FATAL_SW    = 2'd1,
        FATAL_PROTO = 2'd2
    } t_fatal;

    typedef enum logic [1:0] {
        ALARM_NONE   = 2'd0,
        ALARM_CLIENT = 2'd1,
        ALARM_PEER   = 2'd2,
        ALARM_WARN   = 2'd3
    } t_alarm;

    typedef struct packed {
        logic   report_up;
        logic   forward_message;
        t_fatal fatal_notice;
        logic   drop_link;
        logic   disconnect_report;
        t_alarm alarm_kind;
    } t_actions;

endpackage

`default_nettype wire

// File: hw/rtl/btd_next.sv
`default_nettype none

module btd_next (
    input  var btd_pkg::t_state   i_state,
    input  var btd_pkg::t_cmd     i_cmd,
    input  wire                   i_tag_match,
    input  wire                   i_strict,
    output btd_pkg::t_state       o_next_state,
    output btd_pkg::t_actions     o_actions,
    output logic                  o_tag_load
);
    import btd_pkg::*;

    logic     cli_bad;
    logic     peer_bad;
    t_state   nxt;
    t_actions act;

    always_comb begin
        nxt        = i_state;
        act        = '0;
        o_tag_load = 1'b0;
        cli_bad    = 1'b0;
        peer_bad   = 1'b0;

        unique case (i_cmd)
            CMD_CL_SVCDESC: begin
                if (i_state == ST_SVCDESC) begin
                    nxt = ST_IDLE; act.report_up = 1'b1; act.forward_message = 1'b1;
                end else begin
                    cli_bad = 1'b1;
                end
            end
            CMD_CL_BOARDAVAIL: begin
                if (i_state == ST_IDLE) begin
                    nxt = ST_BOARD; act.report_up = 1'b1; act.forward_message = 1'b1;
                end else if (i_state == ST_READY) begin
                    nxt = ST_BOTH; act.report_up = 1'b1; act.forward_message = 1'b1;
                end else if (i_state != ST_TRANSP && i_state != ST_STOPPED) begin
                    cli_bad = 1'b1;
                end
            end
            CMD_CL_REVOKE: begin
                if (i_state == ST_BOARD) begin
                    nxt = ST_IDLE; act.report_up = 1'b1; act.forward_message = 1'b1;
                end else if (i_state == ST_BOTH) begin
                    nxt = ST_READY; act.report_up = 1'b1; act.forward_message = 1'b1;
                end else if (i_state != ST_TRANSP && i_state != ST_STOPPED) begin
                    cli_bad = 1'b1;
                end
            end
            CMD_CL_FINISHED: begin
                if (i_state == ST_TRANSP) begin
                    nxt = ST_FINISHED; act.report_up = 1'b1; act.forward_message = 1'b1;
                end else if (i_state == ST_STOPPED) begin
                    nxt = ST_IDLE; act.report_up = 1'b1; act.forward_message = 1'b1;
                end else begin
                    cli_bad = 1'b1;
                end
            end
            CMD_CL_NOTIF, CMD_CL_ALIVE: begin
                if (i_state != ST_NOTCONN && i_state != ST_DISC) begin
                    act.forward_message = 1'b1;
                end
            end
            CMD_CL_DISCONNECT: begin
                if (i_state != ST_DISC) begin
                    nxt               = ST_DISC;
                    act.report_up     = 1'b1;
                    act.drop_link     = 1'b1;
                    act.forward_message = (i_state != ST_NOTCONN);
                end
            end
            CMD_PR_CONNECTED: begin
                if (i_state == ST_NOTCONN) begin
                    nxt = ST_SOCK; act.report_up = 1'b1;
                end else begin
                    peer_bad = 1'b1;
                end
            end
            CMD_PR_SVCDESC: begin
                if (i_state == ST_SOCK) begin
                    nxt = ST_SVCDESC; act.report_up = 1'b1;
                end else begin
                    peer_bad = 1'b1;
                end
            end
            CMD_PR_READY: begin
                if (i_state == ST_IDLE) begin
                    nxt = ST_READY; act.report_up = 1'b1;
                end else if (i_state == ST_BOARD) begin
                    nxt = ST_BOTH; act.report_up = 1'b1;
                end else begin
                    peer_bad = 1'b1;
                end
            end
            CMD_PR_REVOKERDY: begin
                if (i_state == ST_READY) begin
                    nxt = ST_IDLE; act.report_up = 1'b1;
                end else if (i_state == ST_BOTH) begin
                    nxt = ST_BOARD; act.report_up = 1'b1;
                end else begin
                    peer_bad = 1'b1;
                end
            end
            CMD_PR_START: begin
                if (i_state == ST_READY || i_state == ST_BOTH) begin
                    nxt = ST_TRANSP; act.report_up = 1'b1; o_tag_load = 1'b1;
                end else begin
                    peer_bad = 1'b1;
                end
            end
            CMD_PR_STOP: begin
                if ((i_state == ST_TRANSP || i_state == ST_FINISHED) && i_tag_match) begin
                    nxt = (i_state == ST_TRANSP) ? ST_STOPPED : ST_IDLE;
                    act.report_up = 1'b1;
                end else begin
                    peer_bad = 1'b1;
                end
            end
            CMD_PR_NOTIF, CMD_PR_ALIVE: begin
                if (i_state == ST_NOTCONN || i_state == ST_DISC) begin
                    peer_bad = 1'b1;
                end else begin
                    act.report_up = 1'b1;
                end
            end
            CMD_PR_CLOSED: begin
                if (i_state != ST_DISC) begin
                    nxt = ST_DISC; act.disconnect_report = 1'b1;
                end
            end
            default: begin
                nxt = i_state;
            end
        endcase

        if (cli_bad) begin
            if (!i_strict) begin
                act.alarm_kind      = ALARM_WARN;
                act.forward_message = 1'b1;
            end else begin
                act.alarm_kind = ALARM_CLIENT;
                if (i_state != ST_DISC) begin
                    nxt                   = ST_DISC;
                    act.disconnect_report = 1'b1;
                    act.drop_link         = 1'b1;
                    act.fatal_notice      = (i_state != ST_NOTCONN) ? FATAL_SW : FATAL_NONE;
                end
            end
        end

        if (peer_bad) begin
            act.alarm_kind = ALARM_PEER;
            if (i_state != ST_DISC) begin
                nxt                   = ST_DISC;
                act.disconnect_report = 1'b1;
                act.fatal_notice      = FATAL_PROTO;
                act.drop_link         = 1'b1;
            end
        end

        o_next_state = nxt;
        o_actions    = act;
    end

endmodule

`default_nettype wire

// File: hw/rtl/board_transfer_downstream_fsm.sv
// Downstream board-transfer handshake controller. Each accepted request is one
// event (client or peer message, with a board tag used by start and stop
// transport); each gives exactly one result carrying the new protocol state and
// the action flags. One request is taken every clock cycle unless the input
// stalls; each result passes through the input register, then a combinational
// decode against the state register, into the result register. A stalled
// result holds the input register, so the input stalls only while both
// registers are full and the result is stalled. The strict-checking register is
// written through the configuration channel, which is always ready.
`default_nettype none

module board_transfer_downstream_fsm (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire                               i_cfg_data,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire  [btd_pkg::CMD_W-1:0]         i_cmd,
    input  wire  [btd_pkg::BOARD_TAG_W-1:0]   i_board_tag,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic [btd_pkg::STATE_W-1:0]       o_new_state,
    output logic                              o_report_up,
    output logic                              o_forward_message,
    output logic [1:0]                        o_fatal_notice,
    output logic                              o_drop_link,
    output logic                              o_disconnect_report,
    output logic [1:0]                        o_alarm_kind
);
    import btd_pkg::*;

    logic                 r_strict;
    t_state               r_state;
    logic [TAG_BITS-1:0]  r_started_tag;

    logic                 r_in_valid;
    t_cmd                 r_cmd;
    logic [TAG_BITS-1:0]  r_tag;

    logic                 r_out_valid;
    logic [STATE_W-1:0]   r_new_state;
    t_actions             r_actions;

    t_state               n_state;
    t_actions             n_actions;
    logic                 tag_load;
    logic                 out_free;
    logic                 advance;

    assign out_free    = !r_out_valid || !i_stall;
    assign advance     = r_in_valid && out_free;
    assign o_stall     = r_in_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    btd_next u_next (
        .i_state      (r_state),
        .i_cmd        (r_cmd),
        .i_tag_match  (r_tag == r_started_tag),
        .i_strict     (r_strict),
        .o_next_state (n_state),
        .o_actions    (n_actions),
        .o_tag_load   (tag_load)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict      <= 1'b1;
            r_state       <= ST_NOTCONN;
            r_started_tag <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_strict <= i_cfg_data;
            end
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_state <= n_state;
                if (tag_load) begin
                    r_started_tag <= r_tag;
                end
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_cmd <= t_cmd'(i_cmd);
            r_tag <= i_board_tag[TAG_BITS-1:0];
        end
        if (advance) begin
            r_new_state <= n_state;
            r_actions   <= n_actions;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_new_state         = r_new_state;
    assign o_report_up         = r_actions.report_up;
    assign o_forward_message   = r_actions.forward_message;
    assign o_fatal_notice      = r_actions.fatal_notice;
    assign o_drop_link         = r_actions.drop_link;
    assign o_disconnect_report = r_actions.disconnect_report;
    assign o_alarm_kind        = r_actions.alarm_kind;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import btd_pkg::*;

    localparam int LATENCY        = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 26;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_EVENTS   = 260;
    localparam int PRINT_CAP      = 40;
    localparam logic [BOARD_TAG_W-1:0] TAG_MASK = {BOARD_TAG_W{1'b1}} >> (BOARD_TAG_W - TAG_BITS);

    typedef struct packed {
        t_state                 state;
        logic [BOARD_TAG_W-1:0] tag;
        logic                   strict;
    } t_fsm_ctx;

    typedef struct packed {
        t_state   state;
        t_actions act;
    } t_fsm_out;

    typedef struct packed {
        t_cmd                   cmd;
        logic [BOARD_TAG_W-1:0] tag;
    } t_fsm_event;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    i_cfg_data  = 1'b0;
    logic                    i_valid     = 1'b0;
    logic [CMD_W-1:0]        i_cmd       = '0;
    logic [BOARD_TAG_W-1:0]  i_board_tag = '0;
    logic                    i_stall     = 1'b0;
    logic                    o_cfg_ready;
    logic                    o_stall;
    logic                    o_valid;
    logic [STATE_W-1:0]      o_new_state;
    logic                    o_report_up;
    logic                    o_forward_message;
    logic [1:0]              o_fatal_notice;
    logic                    o_drop_link;
    logic                    o_disconnect_report;
    logic [1:0]              o_alarm_kind;

    t_fsm_event pending_events_q[$];
    t_fsm_out   expected_actions_q[$];
    t_fsm_ctx   model_ctx = '{state: ST_NOTCONN, tag: '0, strict: 1'b1};
    t_fsm_ctx   plan_ctx  = '{state: ST_NOTCONN, tag: '0, strict: 1'b1};

    int unsigned cyc_count     = 0;
    int unsigned stuck_cycles  = 0;
    int unsigned err_count     = 0;
    int unsigned events_sent   = 0;
    int unsigned results_seen  = 0;
    logic [15:0] states_entered = '0;
    logic [1:0]  modes_used     = '0;

    board_transfer_downstream_fsm dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_cmd               (i_cmd),
        .i_board_tag         (i_board_tag),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_new_state         (o_new_state),
        .o_report_up         (o_report_up),
        .o_forward_message   (o_forward_message),
        .o_fatal_notice      (o_fatal_notice),
        .o_drop_link         (o_drop_link),
        .o_disconnect_report (o_disconnect_report),
        .o_alarm_kind        (o_alarm_kind)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void advance(inout t_fsm_out r, input t_state nxt, input bit fwd);
        r.state                 = nxt;
        r.act.report_up         = 1'b1;
        r.act.forward_message   = fwd;
    endfunction

    function automatic t_fsm_out predict_transfer(inout t_fsm_ctx ctx, input t_cmd c,
                                                  input logic [BOARD_TAG_W-1:0] tag_in);
        logic [BOARD_TAG_W-1:0] tag;
        t_state                 s;
        t_fsm_out               r;
        bit                     client_bad;
        bit                     peer_bad;
        tag        = tag_in & TAG_MASK;
        s          = ctx.state;
        r          = '0;
        r.state    = s;
        client_bad = 1'b0;
        peer_bad   = 1'b0;
        case (c)
            CMD_CL_SVCDESC: begin
                if (s == ST_SVCDESC) advance(r, ST_IDLE, 1'b1);
                else client_bad = 1'b1;
            end
            CMD_CL_BOARDAVAIL: begin
                if (s == ST_IDLE) advance(r, ST_BOARD, 1'b1);
                else if (s == ST_READY) advance(r, ST_BOTH, 1'b1);
                else if (s != ST_TRANSP && s != ST_STOPPED) client_bad = 1'b1;
            end
            CMD_CL_REVOKE: begin
                if (s == ST_BOARD) advance(r, ST_IDLE, 1'b1);
                else if (s == ST_BOTH) advance(r, ST_READY, 1'b1);
                else if (s != ST_TRANSP && s != ST_STOPPED) client_bad = 1'b1;
            end
            CMD_CL_FINISHED: begin
                if (s == ST_TRANSP) advance(r, ST_FINISHED, 1'b1);
                else if (s == ST_STOPPED) advance(r, ST_IDLE, 1'b1);
                else client_bad = 1'b1;
            end
            CMD_CL_NOTIF, CMD_CL_ALIVE: begin
                r.act.forward_message = (s != ST_NOTCONN && s != ST_DISC);
            end
            CMD_CL_DISCONNECT: begin
                if (s != ST_DISC) begin
                    advance(r, ST_DISC, s != ST_NOTCONN);
                    r.act.drop_link = 1'b1;
                end
            end
            CMD_PR_CONNECTED: begin
                if (s == ST_NOTCONN) advance(r, ST_SOCK, 1'b0);
                else peer_bad = 1'b1;
            end
            CMD_PR_SVCDESC: begin
                if (s == ST_SOCK) advance(r, ST_SVCDESC, 1'b0);
                else peer_bad = 1'b1;
            end
            CMD_PR_READY: begin
                if (s == ST_IDLE) advance(r, ST_READY, 1'b0);
                else if (s == ST_BOARD) advance(r, ST_BOTH, 1'b0);
                else peer_bad = 1'b1;
            end
            CMD_PR_REVOKERDY: begin
                if (s == ST_READY) advance(r, ST_IDLE, 1'b0);
                else if (s == ST_BOTH) advance(r, ST_BOARD, 1'b0);
                else peer_bad = 1'b1;
            end
            CMD_PR_START: begin
                if (s == ST_READY || s == ST_BOTH) begin
                    ctx.tag = tag;
                    advance(r, ST_TRANSP, 1'b0);
                end else begin
                    peer_bad = 1'b1;
                end
            end
            CMD_PR_STOP: begin
                if ((s == ST_TRANSP || s == ST_FINISHED) && tag == ctx.tag)
                    advance(r, (s == ST_TRANSP) ? ST_STOPPED : ST_IDLE, 1'b0);
                else
                    peer_bad = 1'b1;
            end
            CMD_PR_NOTIF, CMD_PR_ALIVE: begin
                if (s == ST_NOTCONN || s == ST_DISC) peer_bad = 1'b1;
                else r.act.report_up = 1'b1;
            end
            default: begin
                if (s != ST_DISC) begin
                    r.state                 = ST_DISC;
                    r.act.disconnect_report = 1'b1;
                end
            end
        endcase
        if (client_bad) begin
            if (!ctx.strict) begin
                r.act.alarm_kind      = ALARM_WARN;
                r.act.forward_message = 1'b1;
            end else begin
                r.act.alarm_kind = ALARM_CLIENT;
                if (s != ST_DISC) begin
                    r.act.fatal_notice      = (s != ST_NOTCONN) ? FATAL_SW : FATAL_NONE;
                    r.state                 = ST_DISC;
                    r.act.disconnect_report = 1'b1;
                    r.act.drop_link         = 1'b1;
                end
            end
        end
        if (peer_bad) begin
            r.act.alarm_kind = ALARM_PEER;
            if (s != ST_DISC) begin
                r.state                 = ST_DISC;
                r.act.disconnect_report = 1'b1;
                r.act.fatal_notice      = FATAL_PROTO;
                r.act.drop_link         = 1'b1;
            end
        end
        ctx.state = r.state;
        return r;
    endfunction

    function automatic bit kills_link(input t_fsm_ctx ctx, input t_cmd c,
                                      input logic [BOARD_TAG_W-1:0] tag);
        t_fsm_ctx trial;
        t_fsm_out r;
        trial = ctx;
        r     = predict_transfer(trial, c, tag);
        return (ctx.state != ST_DISC) && (r.state == ST_DISC);
    endfunction

    function automatic logic [BOARD_TAG_W-1:0] random_tag();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic bit idle_roll();
        if (cyc_count >= 600 && cyc_count < 1100)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
                     field, results_seen, got, want);
    endtask

    task automatic queue_event(input t_cmd c, input logic [BOARD_TAG_W-1:0] tag);
        t_fsm_out r;
        pending_events_q.push_back('{cmd: c, tag: tag});
        r = predict_transfer(plan_ctx, c, tag);
    endtask

    // draws events until one that does (or does not) bring the link down
    task automatic queue_random(input bit want_kill);
        t_cmd                   c;
        logic [BOARD_TAG_W-1:0] tag;
        do begin
            c   = t_cmd'($urandom_range(0, 15));
            tag = random_tag();
            if (c == CMD_PR_STOP && $urandom_range(0, 9) != 0)
                tag = plan_ctx.tag | (random_tag() & ~TAG_MASK);
        end while (kills_link(plan_ctx, c, tag) != want_kill);
        queue_event(c, tag);
    endtask

    task automatic drain();
        while (pending_events_q.size() != 0 || i_valid || expected_actions_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_strict(input bit mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid     <= 1'b0;
        model_ctx.strict = mode;
        plan_ctx.strict  = mode;
        modes_used[mode] = 1'b1;
        @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_fsm_event ev;
        t_fsm_out   r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r = predict_transfer(model_ctx, t_cmd'(i_cmd), i_board_tag);
                expected_actions_q.push_back(r);
                states_entered[r.state] = 1'b1;
                events_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_events_q.size() != 0 && !idle_roll()) begin
                    ev = pending_events_q.pop_front();
                    i_valid     <= 1'b1;
                    i_cmd       <= ev.cmd;
                    i_board_tag <= ev.tag;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_fsm_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_actions_q.size() == 0) begin
                report_mismatch("unexpected result, state", 64'(o_new_state), 64'(0));
            end else begin
                e = expected_actions_q.pop_front();
                if (o_new_state !== e.state)
                    report_mismatch("new_state", 64'(o_new_state), 64'(e.state));
                if (o_report_up !== e.act.report_up)
                    report_mismatch("report_up", 64'(o_report_up), 64'(e.act.report_up));
                if (o_forward_message !== e.act.forward_message)
                    report_mismatch("forward_message", 64'(o_forward_message),
                                    64'(e.act.forward_message));
                if (o_fatal_notice !== e.act.fatal_notice)
                    report_mismatch("fatal_notice", 64'(o_fatal_notice),
                                    64'(e.act.fatal_notice));
                if (o_drop_link !== e.act.drop_link)
                    report_mismatch("drop_link", 64'(o_drop_link), 64'(e.act.drop_link));
                if (o_disconnect_report !== e.act.disconnect_report)
                    report_mismatch("disconnect_report", 64'(o_disconnect_report),
                                    64'(e.act.disconnect_report));
                if (o_alarm_kind !== e.act.alarm_kind)
                    report_mismatch("alarm_kind", 64'(o_alarm_kind), 64'(e.act.alarm_kind));
            end
        end
        i_stall <= idle_roll();
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("no progress for %0d cycles, %0d requests pending, %0d results owed",
                     WATCHDOG_LIMIT, pending_events_q.size(), expected_actions_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tolerant walk through the whole handshake, transport tags all ones, then all zeros
        write_strict(1'b0);
        queue_event(CMD_CL_NOTIF, '0);
        queue_event(CMD_CL_ALIVE, '1);
        queue_event(CMD_CL_SVCDESC, '0);
        queue_event(CMD_CL_FINISHED, '0);
        queue_event(CMD_CL_BOARDAVAIL, '0);
        queue_event(CMD_PR_CONNECTED, '0);
        queue_event(CMD_CL_REVOKE, '0);
        queue_event(CMD_PR_SVCDESC, '0);
        queue_event(CMD_CL_SVCDESC, '0);
        queue_event(CMD_CL_BOARDAVAIL, '0);
        queue_event(CMD_PR_READY, '0);
        queue_event(CMD_PR_START, '1);
        queue_event(CMD_CL_BOARDAVAIL, '0);
        queue_event(CMD_CL_REVOKE, '0);
        queue_event(CMD_PR_STOP, '1);
        queue_event(CMD_CL_REVOKE, '0);
        queue_event(CMD_CL_FINISHED, '0);
        queue_event(CMD_PR_READY, '0);
        queue_event(CMD_CL_BOARDAVAIL, '0);
        queue_event(CMD_CL_REVOKE, '0);
        queue_event(CMD_PR_START, '0);
        queue_event(CMD_CL_FINISHED, '0);
        queue_event(CMD_PR_STOP, '0);
        queue_event(CMD_PR_NOTIF, '1);
        queue_event(CMD_PR_ALIVE, '0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_strict(p % 2 == 0);
            for (int n = 0; n < PHASE_EVENTS; n++)
                queue_random(1'b0);
            drain();
        end

        // one link-killing event, then everything again while disconnected
        write_strict(1'($urandom_range(0, 1)));
        queue_random(1'b1);
        for (int c = 0; c < 16; c++)
            queue_event(t_cmd'(c), random_tag());
        drain();
        write_strict(!model_ctx.strict);
        for (int c = 0; c < 16; c++)
            queue_event(t_cmd'(c), random_tag());
        for (int n = 0; n < 30; n++)
            queue_random(1'b0);
        drain();

        repeat (4 * LATENCY + 4) @(posedge i_clk);
        if (expected_actions_q.size() != 0)
            report_mismatch("results never delivered", 64'(expected_actions_q.size()),
                            64'(0));

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 events_sent, results_seen, err_count);
        $display("%0d of 11 protocol states entered, strict mode %0s and tolerant mode %0s",
                 $countones(states_entered), modes_used[1] ? "used" : "unused",
                 modes_used[0] ? "used" : "unused");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
